FILE: rtl/shape_record_stream_parser_assert.svh
// Assertion macros used by the checker file.
`ifndef SHAPE_RECORD_STREAM_PARSER_ASSERT_SVH
`define SHAPE_RECORD_STREAM_PARSER_ASSERT_SVH

// Checked only outside reset.
`define SRSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SRSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/srsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srsp_pkg;

   localparam int RES_MAX = 3;
   localparam int QUEUE_DEPTH = 8;

   localparam logic [31:0] FILE_MAGIC = 32'h0000_270a;
   localparam logic [8:0] TYPE_MULTIPOINT = 9'd8;
   localparam logic [31:0] TYPE_LIMIT = 32'd256;
   localparam logic [31:0] MULTI_MIN_BYTES = 32'd36;

   localparam logic [2:0] KIND_HEADER_OK = 3'd0;
   localparam logic [2:0] KIND_BOX_MIN = 3'd1;
   localparam logic [2:0] KIND_BOX_MAX = 3'd2;
   localparam logic [2:0] KIND_RECORD = 3'd3;
   localparam logic [2:0] KIND_COUNTS = 3'd4;
   localparam logic [2:0] KIND_POINT = 3'd5;
   localparam logic [2:0] KIND_SEPARATOR = 3'd6;
   localparam logic [2:0] KIND_END = 3'd7;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
   localparam logic [2:0] ST_BAD_RECORD = 3'd2;
   localparam logic [2:0] ST_SHORT_MULTI = 3'd3;
   localparam logic [2:0] ST_BAD_COUNT = 3'd4;
   localparam logic [2:0] ST_TRUNCATED = 3'd5;
   localparam logic [2:0] ST_TOO_MANY = 3'd6;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_RECHDR,
      PH_BOX,
      PH_COUNTS,
      PH_PARTS,
      PH_POINTS,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] status;
      logic [31:0] record_id;
      logic [8:0] shape_type;
      logic [8:0] part_index;
      logic [8:0] part_count;
      logic [30:0] point_count;
      logic [63:0] x_bits;
      logic [63:0] y_bits;
      logic run_end;
   } item_type;

   typedef struct packed {
      logic [1:0] count;
      item_type [RES_MAX-1:0] items;
   } batch_type;

   function automatic logic [63:0] swap64(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = v[8*(7-i) +: 8];
      end
      return r;
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic is_poly(input logic [8:0] t);
      return (t == 9'd3) || (t == 9'd5) || (t == 9'd13) || (t == 9'd15);
   endfunction

   function automatic item_type make_item(
      input logic [2:0] kind,
      input logic [2:0] status,
      input logic [8:0] pidx,
      input logic [8:0] pcnt,
      input logic [30:0] pts,
      input logic [63:0] x,
      input logic [63:0] y
   );
      item_type it;
      it = '0;
      it.kind = kind;
      it.status = status;
      it.part_index = pidx;
      it.part_count = pcnt;
      it.point_count = pts;
      it.x_bits = x;
      it.y_bits = y;
      return it;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/shape_record_stream_parser.sv
//  Channel  Direction  Handshake          Payload
//  req      in         req_push/req_full  req_data_byte, req_stream_end
//  rsp      out        rsp_pop/rsp_empty  kind, status, ids, counts, coordinates
//  csr      in         csr_wr_en          csr_wr_data (separator mode)
//
//  One byte is accepted per cycle while req_full is low; each byte's results, up to three,
//  enter an eight-entry result queue in the same cycle and leave it one per cycle while rsp_pop is high.
//  req_full rises while fewer than three queue slots are free, so the result
//  drain rate of one per cycle sets the sustained rate when results are dense.
//  Reset is synchronous and clears all control state; there is no clearing pass.
//  After the end result every byte is accepted and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none
module shape_record_stream_parser #(
   parameter int MAX_PARTS = 256
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire logic [7:0] req_data_byte,
   input wire logic req_stream_end,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output logic [2:0] rsp_kind,
   output logic [2:0] rsp_status,
   output logic signed [31:0] rsp_record_id,
   output logic [8:0] rsp_shape_type,
   output logic [8:0] rsp_part_index,
   output logic [8:0] rsp_part_count,
   output logic [30:0] rsp_point_count,
   output logic [63:0] rsp_x_bits,
   output logic [63:0] rsp_y_bits,
   output logic rsp_run_end,
   input wire logic csr_wr_en,
   input wire logic csr_wr_data
);

   srsp_pkg::batch_type batch;
   srsp_pkg::item_type head;

   srsp_front #(
      .MAX_PARTS(MAX_PARTS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data_byte(req_data_byte),
      .req_stream_end(req_stream_end),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .batch(batch)
   );

   srsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .batch(batch),
      .full(req_full),
      .empty(rsp_empty),
      .pop(rsp_pop),
      .head(head)
   );

   assign rsp_kind = head.kind;
   assign rsp_status = head.status;
   assign rsp_record_id = $signed(head.record_id);
   assign rsp_shape_type = head.shape_type;
   assign rsp_part_index = head.part_index;
   assign rsp_part_count = head.part_count;
   assign rsp_point_count = head.point_count;
   assign rsp_x_bits = head.x_bits;
   assign rsp_y_bits = head.y_bits;
   assign rsp_run_end = head.run_end;

endmodule
`default_nettype wire

FILE: rtl/srsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module srsp_front #(
   parameter int MAX_PARTS = 256
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   input wire logic req_full,
   input wire logic [7:0] req_data_byte,
   input wire logic req_stream_end,
   input wire logic csr_wr_en,
   input wire logic csr_wr_data,
   output srsp_pkg::batch_type batch
);

   localparam int PW = $clog2(MAX_PARTS + 1);
   localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int SPAN = (4 * MAX_PARTS > 100) ? 4 * MAX_PARTS : 100;
   localparam int CW = $clog2(SPAN + 1);

   srsp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] flen_ff, flen_in;
   logic [63:0] shift_ff, shift_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] rec_id_ff, rec_id_in;
   logic [31:0] rec_end_ff, rec_end_in;
   logic [8:0] ctype_ff, ctype_in;
   logic [PW-1:0] parts_ff, parts_in;
   logic [30:0] points_ff, points_in;
   logic [30:0] seen_ff, seen_in;
   logic [PW-1:0] cursor_ff, cursor_in;
   logic [63:0] xhold_ff, xhold_in;
   logic sep_ff;
   logic [31:0] tbl_rd_ff;
   logic [31:0] part_start_ff [MAX_PARTS];
   logic tbl_we;
   logic [AW-1:0] tbl_wa;
   logic [31:0] tbl_wd;
   logic accept;

   assign accept = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= srsp_pkg::PH_HEADER;
         pos_ff <= '0;
         flen_ff <= '0;
         shift_ff <= '0;
         cnt_ff <= '0;
         rec_id_ff <= '0;
         rec_end_ff <= '0;
         ctype_ff <= '0;
         parts_ff <= '0;
         points_ff <= '0;
         seen_ff <= '0;
         cursor_ff <= '0;
         xhold_ff <= '0;
         sep_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         flen_ff <= flen_in;
         shift_ff <= shift_in;
         cnt_ff <= cnt_in;
         rec_id_ff <= rec_id_in;
         rec_end_ff <= rec_end_in;
         ctype_ff <= ctype_in;
         parts_ff <= parts_in;
         points_ff <= points_in;
         seen_ff <= seen_in;
         cursor_ff <= cursor_in;
         xhold_ff <= xhold_in;
         if (csr_wr_en) begin
            sep_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         part_start_ff[tbl_wa] <= tbl_wd;
      end
      tbl_rd_ff <= part_start_ff[cursor_ff[AW-1:0]];
   end

   always_comb begin
      logic [63:0] sh;
      logic [CW-1:0] k;
      logic [31:0] lo_le;
      logic [31:0] hi_le;
      logic [32:0] end_sum;
      logic [31:0] base;
      logic [31:0] np;
      logic [31:0] bound;
      logic [CW:0] idx1;
      logic [PW-1:0] cur_next;
      logic multi;
      logic trunc;
      logic fin;
      logic [2:0] fst;
      logic go_end_record;
      logic go_boundary;
      logic [1:0] n;
      srsp_pkg::item_type [srsp_pkg::RES_MAX-1:0] items;

      phase_in = phase_ff;
      pos_in = pos_ff;
      flen_in = flen_ff;
      shift_in = shift_ff;
      cnt_in = cnt_ff;
      rec_id_in = rec_id_ff;
      rec_end_in = rec_end_ff;
      ctype_in = ctype_ff;
      parts_in = parts_ff;
      points_in = points_ff;
      seen_in = seen_ff;
      cursor_in = cursor_ff;
      xhold_in = xhold_ff;
      tbl_we = 1'b0;
      tbl_wa = '0;
      tbl_wd = '0;
      items = '0;
      n = '0;
      fin = 1'b0;
      fst = srsp_pkg::ST_OK;
      go_end_record = 1'b0;
      go_boundary = 1'b0;
      trunc = 1'b0;
      sh = {shift_ff[55:0], req_data_byte};
      k = cnt_ff;
      lo_le = srsp_pkg::swap32(sh[31:0]);
      hi_le = srsp_pkg::swap32(sh[63:32]);
      end_sum = '0;
      base = '0;
      np = '0;
      bound = '0;
      idx1 = '0;
      cur_next = cursor_ff;
      multi = (ctype_ff == srsp_pkg::TYPE_MULTIPOINT);

      if (accept && phase_ff != srsp_pkg::PH_DONE) begin
         pos_in = (pos_ff == '1) ? pos_ff : pos_ff + 32'd1;
         shift_in = sh;
         cnt_in = cnt_ff + CW'(1);

         unique case (phase_ff)
            srsp_pkg::PH_HEADER: begin
               if (k == CW'(3)) begin
                  if (sh[31:0] != srsp_pkg::FILE_MAGIC) begin
                     fin = 1'b1;
                     fst = srsp_pkg::ST_BAD_MAGIC;
                  end
               end else if (k == CW'(27)) begin
                  flen_in = sh[31] ? 32'd0 : {sh[30:0], 1'b0};
               end else if (k == CW'(35)) begin
                  ctype_in = lo_le[8:0];
                  items[n] = srsp_pkg::make_item(srsp_pkg::KIND_HEADER_OK, srsp_pkg::ST_OK,
                     '0, '0, '0, '0, '0);
                  n = n + 2'd1;
               end else if (k == CW'(43) || k == CW'(59)) begin
                  xhold_in = srsp_pkg::swap64(sh);
               end else if (k == CW'(51)) begin
                  items[n] = srsp_pkg::make_item(srsp_pkg::KIND_BOX_MIN, srsp_pkg::ST_OK,
                     '0, '0, '0, xhold_ff, srsp_pkg::swap64(sh));
                  n = n + 2'd1;
               end else if (k == CW'(67)) begin
                  items[n] = srsp_pkg::make_item(srsp_pkg::KIND_BOX_MAX, srsp_pkg::ST_OK,
                     '0, '0, '0, xhold_ff, srsp_pkg::swap64(sh));
                  n = n + 2'd1;
               end else if (k == CW'(99)) begin
                  go_boundary = 1'b1;
               end
            end
            srsp_pkg::PH_RECHDR: begin
               if (k == CW'(3)) begin
                  rec_id_in = sh[31:0];
               end else if (k == CW'(7)) begin
                  if (sh[31]) begin
                     fin = 1'b1;
                     fst = srsp_pkg::ST_BAD_RECORD;
                  end else begin
                     end_sum = {1'b0, pos_in} + {1'b0, sh[30:0], 1'b0};
                     rec_end_in = end_sum[32] ? '1 : end_sum[31:0];
                  end
               end else if (k == CW'(11)) begin
                  if (lo_le[31] || lo_le > srsp_pkg::TYPE_LIMIT) begin
                     fin = 1'b1;
                     fst = srsp_pkg::ST_BAD_RECORD;
                  end else begin
                     ctype_in = lo_le[8:0];
                     base = pos_in - 32'd4;
                     if (srsp_pkg::is_poly(lo_le[8:0])) begin
                        items[n] = srsp_pkg::make_item(srsp_pkg::KIND_RECORD,
                           srsp_pkg::ST_OK, '0, '0, '0, '0, '0);
                        n = n + 2'd1;
                        phase_in = srsp_pkg::PH_BOX;
                        cnt_in = '0;
                        shift_in = '0;
                     end else if (lo_le[8:0] == srsp_pkg::TYPE_MULTIPOINT) begin
                        if (rec_end_ff < base ||
                            (rec_end_ff - base) < srsp_pkg::MULTI_MIN_BYTES) begin
                           fin = 1'b1;
                           fst = srsp_pkg::ST_SHORT_MULTI;
                        end else begin
                           items[n] = srsp_pkg::make_item(srsp_pkg::KIND_RECORD,
                              srsp_pkg::ST_OK, '0, '0, '0, '0, '0);
                           n = n + 2'd1;
                           phase_in = srsp_pkg::PH_BOX;
                           cnt_in = '0;
                           shift_in = '0;
                        end
                     end else begin
                        go_end_record = 1'b1;
                     end
                  end
               end
            end
            srsp_pkg::PH_BOX: begin
               if (k == CW'(7) || k == CW'(23)) begin
                  xhold_in = srsp_pkg::swap64(sh);
               end else if (k == CW'(15)) begin
                  items[n] = srsp_pkg::make_item(srsp_pkg::KIND_BOX_MIN, srsp_pkg::ST_OK,
                     '0, '0, '0, xhold_ff, srsp_pkg::swap64(sh));
                  n = n + 2'd1;
               end else if (k == CW'(31)) begin
                  items[n] = srsp_pkg::make_item(srsp_pkg::KIND_BOX_MAX, srsp_pkg::ST_OK,
                     '0, '0, '0, xhold_ff, srsp_pkg::swap64(sh));
                  n = n + 2'd1;
                  phase_in = srsp_pkg::PH_COUNTS;
                  cnt_in = '0;
                  shift_in = '0;
               end
            end
            srsp_pkg::PH_COUNTS: begin
               if (k == (multi ? CW'(3) : CW'(7))) begin
                  np = multi ? 32'd0 : hi_le;
                  if (np[31] || lo_le[31]) begin
                     fin = 1'b1;
                     fst = srsp_pkg::ST_BAD_COUNT;
                  end else if (np > 32'(MAX_PARTS)) begin
                     fin = 1'b1;
                     fst = srsp_pkg::ST_TOO_MANY;
                  end else begin
                     parts_in = PW'(np);
                     points_in = lo_le[30:0];
                     seen_in = '0;
                     cursor_in = multi ? PW'(0) : PW'(1);
                     items[n] = srsp_pkg::make_item(srsp_pkg::KIND_COUNTS, srsp_pkg::ST_OK,
                        '0, 9'(np), lo_le[30:0], '0, '0);
                     n = n + 2'd1;
                     cnt_in = '0;
                     shift_in = '0;
                     if (np != 32'd0) begin
                        phase_in = srsp_pkg::PH_PARTS;
                     end else if (lo_le[30:0] != 31'd0) begin
                        phase_in = srsp_pkg::PH_POINTS;
                     end else begin
                        go_end_record = 1'b1;
                     end
                  end
               end
            end
            srsp_pkg::PH_PARTS: begin
               if (k[1:0] == 2'd3) begin
                  tbl_we = 1'b1;
                  tbl_wa = AW'(k[CW-1:2]);
                  tbl_wd = lo_le;
                  idx1 = (CW+1)'(k[CW-1:2]) + (CW+1)'(1);
                  if (idx1 >= (CW+1)'(parts_ff)) begin
                     if (points_ff != 31'd0) begin
                        phase_in = srsp_pkg::PH_POINTS;
                        cnt_in = '0;
                        shift_in = '0;
                     end else begin
                        go_end_record = 1'b1;
                     end
                  end
               end
            end
            srsp_pkg::PH_POINTS: begin
               if (k == CW'(7)) begin
                  xhold_in = srsp_pkg::swap64(sh);
               end else if (k == CW'(15)) begin
                  if (!multi) begin
                     bound = (cursor_ff < parts_ff) ? tbl_rd_ff : {1'b0, points_ff};
                     if ({1'b0, seen_ff} == bound) begin
                        cur_next = cursor_ff + PW'(1);
                        cursor_in = cur_next;
                        if (sep_ff) begin
                           items[n] = srsp_pkg::make_item(srsp_pkg::KIND_SEPARATOR,
                              srsp_pkg::ST_OK, 9'(cur_next), '0, '0, '0, '0);
                           n = n + 2'd1;
                        end
                     end
                  end
                  items[n] = srsp_pkg::make_item(srsp_pkg::KIND_POINT, srsp_pkg::ST_OK,
                     multi ? 9'd0 : 9'(cur_next), '0, '0, xhold_ff,
                     srsp_pkg::swap64(sh));
                  n = n + 2'd1;
                  seen_in = seen_ff + 31'd1;
                  if (seen_in >= points_ff) begin
                     go_end_record = 1'b1;
                  end else begin
                     cnt_in = '0;
                     shift_in = '0;
                  end
               end
            end
            srsp_pkg::PH_SKIP: begin
               if (pos_in >= rec_end_ff) begin
                  go_boundary = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (go_end_record) begin
            if (pos_in >= rec_end_in) begin
               go_boundary = 1'b1;
            end else begin
               phase_in = srsp_pkg::PH_SKIP;
            end
         end
         if (go_boundary) begin
            phase_in = srsp_pkg::PH_RECHDR;
            cnt_in = '0;
            shift_in = '0;
            if (pos_in >= flen_in) begin
               fin = 1'b1;
               fst = srsp_pkg::ST_OK;
            end
         end

         if (!fin && req_stream_end) begin
            case (phase_in)
               srsp_pkg::PH_RECHDR: trunc = (cnt_in != '0) && (cnt_in < CW'(8));
               srsp_pkg::PH_SKIP: trunc = 1'b0;
               default: trunc = 1'b1;
            endcase
            fin = 1'b1;
            fst = trunc ? srsp_pkg::ST_TRUNCATED : srsp_pkg::ST_OK;
         end

         if (fin) begin
            items[n] = srsp_pkg::make_item(srsp_pkg::KIND_END, fst, '0, '0, '0, '0, '0);
            n = n + 2'd1;
            phase_in = srsp_pkg::PH_DONE;
         end

         if (n != 2'd0) begin
            items[n - 2'd1].run_end = 1'b1;
         end
      end

      for (int i = 0; i < srsp_pkg::RES_MAX; i++) begin
         items[i].record_id = rec_id_in;
         items[i].shape_type = ctype_in;
      end

      batch.count = n;
      batch.items = items;
   end

endmodule
`default_nettype wire

FILE: rtl/srsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module srsp_queue (
   input wire logic clock,
   input wire logic reset,
   input wire srsp_pkg::batch_type batch,
   output logic full,
   output logic empty,
   input wire logic pop,
   output srsp_pkg::item_type head
);

   localparam int QAW = $clog2(srsp_pkg::QUEUE_DEPTH);
   localparam int QCW = $clog2(srsp_pkg::QUEUE_DEPTH + 1);

   srsp_pkg::item_type slot_ff [srsp_pkg::QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic take;

   assign empty = (count_ff == '0);
   assign full = (count_ff > QCW'(srsp_pkg::QUEUE_DEPTH - srsp_pkg::RES_MAX));
   assign take = pop && !empty;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QAW'(batch.count);
      rd_ptr_in = take ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in = count_ff + QCW'(batch.count) - (take ? QCW'(1) : QCW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < srsp_pkg::RES_MAX; i++) begin
         if (2'(i) < batch.count) begin
            slot_ff[wr_ptr_ff + QAW'(i)] <= batch.items[i];
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/srsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "shape_record_stream_parser_assert.svh"
module srsp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_empty,
   input wire logic rsp_pop,
   input wire logic [2:0] rsp_kind,
   input wire logic [2:0] rsp_status,
   input wire logic rsp_run_end
);

   `SRSP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty, "queue not empty after reset")
   `SRSP_ASSERT(a_status_on_end, clock, reset, !rsp_empty |-> (rsp_status == srsp_pkg::ST_OK || rsp_kind == srsp_pkg::KIND_END), "status on a non-end result")
   `SRSP_ASSERT(a_end_closes_run, clock, reset, (!rsp_empty && rsp_kind == srsp_pkg::KIND_END) |-> rsp_run_end, "end result does not close its run")
   `SRSP_ASSERT(a_stall_holds, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_kind)), "stalled result changed")

endmodule

bind shape_record_stream_parser srsp_checker u_srsp_checker (
   .clock(clock),
   .reset(reset),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_kind(rsp_kind),
   .rsp_status(rsp_status),
   .rsp_run_end(rsp_run_end)
);
`default_nettype wire

FILE: tb/shape_record_stream_parser_test.sv
`timescale 1ns / 1ps
module shape_record_stream_parser_test;

   localparam int STALL_LIMIT = 4000;
   localparam int PART_LIMIT = 256;
   localparam logic [31:0] POS_TOP = 32'hFFFF_FFFF;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [7:0] req_data_byte;
   logic req_stream_end;
   logic rsp_empty;
   logic rsp_pop;
   logic [2:0] rsp_kind;
   logic [2:0] rsp_status;
   logic signed [31:0] rsp_record_id;
   logic [8:0] rsp_shape_type;
   logic [8:0] rsp_part_index;
   logic [8:0] rsp_part_count;
   logic [30:0] rsp_point_count;
   logic [63:0] rsp_x_bits;
   logic [63:0] rsp_y_bits;
   logic rsp_run_end;
   logic csr_wr_en;
   logic csr_wr_data;

   shape_record_stream_parser dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data_byte(req_data_byte),
      .req_stream_end(req_stream_end),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_status(rsp_status),
      .rsp_record_id(rsp_record_id),
      .rsp_shape_type(rsp_shape_type),
      .rsp_part_index(rsp_part_index),
      .rsp_part_count(rsp_part_count),
      .rsp_point_count(rsp_point_count),
      .rsp_x_bits(rsp_x_bits),
      .rsp_y_bits(rsp_y_bits),
      .rsp_run_end(rsp_run_end),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Parser state mirrored by the predictor.
   logic [31:0] pos;
   logic [31:0] file_bytes;
   srsp_pkg::phase_type phase;
   logic [63:0] shifter;
   logic [31:0] field_cnt;
   logic [31:0] rec_id;
   logic [31:0] rec_end;
   logic [8:0] cur_type;
   logic [31:0] n_parts;
   logic [31:0] n_points;
   logic [31:0] pts_done;
   logic [31:0] cursor;
   logic [31:0] part_starts [PART_LIMIT];
   logic [63:0] x_saved;
   bit parse_done;
   bit sep_mode;

   srsp_pkg::item_type byte_items [$];
   srsp_pkg::item_type expected_items [$];
   logic [7:0] stream_bytes [$];
   bit stream_last [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int failures;
   int bytes_sent;
   int items_checked;
   int stall_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] rev32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [63:0] rev64(input logic [63:0] v);
      return {rev32(v[31:0]), rev32(v[63:32])};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic note(input logic [2:0] kind, input logic [2:0] status,
                       input logic [31:0] pidx, input logic [31:0] pcnt,
                       input logic [31:0] pts, input logic [63:0] x, input logic [63:0] y);
      srsp_pkg::item_type it;
      if (byte_items.size() < srsp_pkg::RES_MAX) begin
         it = '0;
         it.kind = kind;
         it.status = status;
         it.record_id = rec_id;
         it.shape_type = cur_type;
         it.part_index = pidx[8:0];
         it.part_count = pcnt[8:0];
         it.point_count = pts[30:0];
         it.x_bits = x;
         it.y_bits = y;
         byte_items.push_back(it);
      end
   endtask

   task automatic stop_parse(input logic [2:0] status);
      note(srsp_pkg::KIND_END, status, 0, 0, 0, 0, 0);
      parse_done = 1'b1;
      phase = srsp_pkg::PH_DONE;
   endtask

   task automatic enter(input srsp_pkg::phase_type ph);
      phase = ph;
      field_cnt = 0;
      shifter = 0;
   endtask

   task automatic record_boundary();
      enter(srsp_pkg::PH_RECHDR);
      if (pos >= file_bytes) stop_parse(srsp_pkg::ST_OK);
   endtask

   task automatic close_record();
      if (pos >= rec_end) record_boundary();
      else phase = srsp_pkg::PH_SKIP;
   endtask

   task automatic parts_taken();
      if (n_points > 0) enter(srsp_pkg::PH_POINTS);
      else close_record();
   endtask

   task automatic take_counts();
      bit multi;
      logic signed [31:0] np;
      logic signed [31:0] nt;
      multi = (cur_type == srsp_pkg::TYPE_MULTIPOINT);
      np = multi ? 32'sd0 : $signed(rev32(shifter[63:32]));
      nt = $signed(rev32(shifter[31:0]));
      if (np < 0 || nt < 0) begin
         stop_parse(srsp_pkg::ST_BAD_COUNT);
      end else if (np > PART_LIMIT) begin
         stop_parse(srsp_pkg::ST_TOO_MANY);
      end else begin
         n_parts = np;
         n_points = nt;
         pts_done = 0;
         cursor = multi ? 0 : 1;
         note(srsp_pkg::KIND_COUNTS, srsp_pkg::ST_OK, 0, n_parts, n_points, 0, 0);
         if (n_parts > 0) enter(srsp_pkg::PH_PARTS);
         else parts_taken();
      end
   endtask

   task automatic take_point(input logic [63:0] y);
      logic [31:0] bound;
      logic [31:0] pidx;
      pidx = 0;
      if (cur_type != srsp_pkg::TYPE_MULTIPOINT) begin
         bound = (cursor < n_parts && cursor < PART_LIMIT) ? part_starts[cursor] : n_points;
         if (pts_done == bound) begin
            cursor++;
            if (sep_mode) note(srsp_pkg::KIND_SEPARATOR, srsp_pkg::ST_OK, cursor, 0, 0, 0, 0);
         end
         pidx = cursor;
      end
      note(srsp_pkg::KIND_POINT, srsp_pkg::ST_OK, pidx, 0, 0, x_saved, y);
      pts_done++;
      if (pts_done >= n_points) close_record();
      else enter(srsp_pkg::PH_POINTS);
   endtask

   task automatic take_type();
      logic signed [31:0] sty;
      logic [31:0] base;
      sty = $signed(rev32(shifter[31:0]));
      if (sty < 0 || sty > 256) begin
         stop_parse(srsp_pkg::ST_BAD_RECORD);
      end else begin
         cur_type = sty[8:0];
         if (srsp_pkg::is_poly(cur_type)) begin
            note(srsp_pkg::KIND_RECORD, srsp_pkg::ST_OK, 0, 0, 0, 0, 0);
            enter(srsp_pkg::PH_BOX);
         end else if (cur_type == srsp_pkg::TYPE_MULTIPOINT) begin
            base = pos - 32'd4;
            if (rec_end < base || rec_end - base < srsp_pkg::MULTI_MIN_BYTES) begin
               stop_parse(srsp_pkg::ST_SHORT_MULTI);
            end else begin
               note(srsp_pkg::KIND_RECORD, srsp_pkg::ST_OK, 0, 0, 0, 0, 0);
               enter(srsp_pkg::PH_BOX);
            end
         end else begin
            close_record();
         end
      end
   endtask

   task automatic take_record_header(input logic [31:0] k);
      logic signed [31:0] len;
      logic [32:0] stop_at;
      if (k == 3) begin
         rec_id = shifter[31:0];
      end else if (k == 7) begin
         len = $signed(shifter[31:0]);
         if (len < 0) begin
            stop_parse(srsp_pkg::ST_BAD_RECORD);
         end else begin
            stop_at = {1'b0, pos} + {len[31:0], 1'b0};
            rec_end = stop_at[32] ? POS_TOP : stop_at[31:0];
         end
      end else if (k == 11) begin
         take_type();
      end
   endtask

   task automatic take_header(input logic [31:0] k);
      logic signed [31:0] w;
      logic [31:0] t;
      if (k == 3) begin
         if (shifter[31:0] != srsp_pkg::FILE_MAGIC) stop_parse(srsp_pkg::ST_BAD_MAGIC);
      end else if (k == 27) begin
         w = $signed(shifter[31:0]);
         file_bytes = (w < 0) ? 32'd0 : {w[30:0], 1'b0};
      end else if (k == 35) begin
         t = rev32(shifter[31:0]);
         cur_type = t[8:0];
         note(srsp_pkg::KIND_HEADER_OK, srsp_pkg::ST_OK, 0, 0, 0, 0, 0);
      end else if (k == 43 || k == 59) begin
         x_saved = rev64(shifter);
      end else if (k == 51) begin
         note(srsp_pkg::KIND_BOX_MIN, srsp_pkg::ST_OK, 0, 0, 0, x_saved, rev64(shifter));
      end else if (k == 67) begin
         note(srsp_pkg::KIND_BOX_MAX, srsp_pkg::ST_OK, 0, 0, 0, x_saved, rev64(shifter));
      end else if (k == 99) begin
         record_boundary();
      end
   endtask

   task automatic predict_byte(input logic [7:0] b, input bit last);
      logic [31:0] k;
      bit trunc;
      byte_items.delete();
      if (!parse_done) begin
         if (pos != POS_TOP) pos++;
         shifter = {shifter[55:0], b};
         k = field_cnt;
         field_cnt++;
         case (phase)
            srsp_pkg::PH_HEADER: take_header(k);
            srsp_pkg::PH_RECHDR: take_record_header(k);
            srsp_pkg::PH_BOX: begin
               if (k == 7 || k == 23) begin
                  x_saved = rev64(shifter);
               end else if (k == 15) begin
                  note(srsp_pkg::KIND_BOX_MIN, srsp_pkg::ST_OK, 0, 0, 0, x_saved,
                       rev64(shifter));
               end else if (k == 31) begin
                  note(srsp_pkg::KIND_BOX_MAX, srsp_pkg::ST_OK, 0, 0, 0, x_saved,
                       rev64(shifter));
                  enter(srsp_pkg::PH_COUNTS);
               end
            end
            srsp_pkg::PH_COUNTS: begin
               if (k == ((cur_type == srsp_pkg::TYPE_MULTIPOINT) ? 3 : 7)) take_counts();
            end
            srsp_pkg::PH_PARTS: begin
               if (k[1:0] == 2'd3) begin
                  if ((k >> 2) < PART_LIMIT) part_starts[k >> 2] = rev32(shifter[31:0]);
                  if ((k >> 2) + 1 >= n_parts) parts_taken();
               end
            end
            srsp_pkg::PH_POINTS: begin
               if (k == 7) x_saved = rev64(shifter);
               else if (k == 15) take_point(rev64(shifter));
            end
            srsp_pkg::PH_SKIP: begin
               if (pos >= rec_end) record_boundary();
            end
            default: ;
         endcase
         if (!parse_done && last) begin
            case (phase)
               srsp_pkg::PH_HEADER, srsp_pkg::PH_BOX, srsp_pkg::PH_COUNTS,
               srsp_pkg::PH_PARTS, srsp_pkg::PH_POINTS: trunc = 1'b1;
               srsp_pkg::PH_RECHDR: trunc = field_cnt > 0 && field_cnt < 8;
               default: trunc = 1'b0;
            endcase
            stop_parse(trunc ? srsp_pkg::ST_TRUNCATED : srsp_pkg::ST_OK);
         end
         if (byte_items.size() > 0) byte_items[byte_items.size() - 1].run_end = 1'b1;
         foreach (byte_items[i]) expected_items.push_back(byte_items[i]);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= b;
      req_stream_end <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_byte(b, last);
      bytes_sent++;
   endtask

   task automatic flush_stream();
      while (stream_bytes.size() > 0) send_byte(stream_bytes.pop_front(), stream_last.pop_front());
      req_push <= 1'b0;
      req_stream_end <= 1'b0;
   endtask

   task automatic put8(input logic [7:0] b);
      stream_bytes.push_back(b);
      stream_last.push_back(1'b0);
   endtask

   task automatic put_be32(input logic [31:0] v);
      for (int i = 3; i >= 0; i--) put8(v[8*i +: 8]);
   endtask

   task automatic put_le32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) put8(v[8*i +: 8]);
   endtask

   task automatic put_le64(input logic [63:0] v);
      for (int i = 0; i < 8; i++) put8(v[8*i +: 8]);
   endtask

   task automatic put_box();
      for (int i = 0; i < 4; i++) put_le64(rand64());
   endtask

   // Header with the file length that the caller gives, in 16-bit words.
   task automatic put_header(input logic [31:0] len_words);
      put_be32(srsp_pkg::FILE_MAGIC);
      for (int i = 4; i < 24; i++) put8($urandom_range(0, 255));
      put_be32(len_words);
      put_le32($urandom());
      put_le32($urandom_range(0, 1) ? 32'd5 : $urandom());
      put_box();
      for (int i = 68; i < 100; i++) put8($urandom_range(0, 255));
   endtask

   // Polygon or polyline record. Order selects sorted part starts, else random ones.
   task automatic put_poly(input logic [31:0] id, input logic [31:0] st, input int np,
                           input int npt, input bit order, input int tail, input int len_adj);
      int content;
      int next;
      content = 44 + 4 * np + 16 * npt + tail;
      put_be32(id);
      put_be32(content / 2 + len_adj);
      put_le32(st);
      put_box();
      put_le32(np);
      put_le32(npt);
      next = 0;
      for (int i = 0; i < np; i++) begin
         if (order) begin
            put_le32(next);
            next = next + $urandom_range(0, 3);
            if (next > npt) next = npt;
         end else begin
            put_le32($urandom_range(0, npt + 1));
         end
      end
      for (int i = 0; i < 2 * npt; i++) put_le64(rand64());
      for (int i = 0; i < tail; i++) put8($urandom_range(0, 255));
   endtask

   task automatic put_multi(input logic [31:0] id, input int npt, input int tail);
      put_be32(id);
      put_be32((40 + 16 * npt + tail) / 2);
      put_le32(32'(srsp_pkg::TYPE_MULTIPOINT));
      put_box();
      put_le32(npt);
      for (int i = 0; i < 2 * npt; i++) put_le64(rand64());
      for (int i = 0; i < tail; i++) put8($urandom_range(0, 255));
   endtask

   task automatic put_other(input logic [31:0] id, input logic [31:0] st, input int nbytes);
      put_be32(id);
      put_be32((4 + nbytes) / 2);
      put_le32(st);
      for (int i = 0; i < nbytes; i++) put8($urandom_range(0, 255));
   endtask

   function automatic logic [31:0] poly_type();
      case ($urandom_range(0, 3))
         0: return 32'd3;
         1: return 32'd5;
         2: return 32'd13;
         default: return 32'd15;
      endcase
   endfunction

   task automatic put_random_record();
      int pick;
      int npt;
      pick = $urandom_range(0, 99);
      npt = $urandom_range(0, 2);
      if (pick < 55) begin
         put_poly($urandom(), poly_type(), $urandom_range(0, 2), npt, $urandom_range(0, 3) != 0,
                  2 * $urandom_range(0, 1), 0);
      end else if (pick < 75) begin
         put_multi($urandom(), npt, 2 * $urandom_range(0, 1));
      end else if (pick < 87) begin
         put_other($urandom(), $urandom_range(0, 256), 2 * $urandom_range(0, 2));
      end else begin
         // Declared length shorter or longer than the fields.
         put_poly($urandom(), poly_type(), $urandom_range(1, 2), npt, 1'b1, 0,
                  $urandom_range(0, 1) ? -$urandom_range(1, 10) : $urandom_range(1, 4));
      end
   endtask

   task automatic wait_drained(input int extra);
      while (expected_items.size() > 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_separator(input bit v);
      wait_drained(4);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sep_mode = v;
   endtask

   task automatic test_header();
      put_header($urandom_range(0, 9) == 0 ? $urandom_range(100, 600) : 32'h3FFF_FFFF);
      flush_stream();
   endtask

   task automatic test_directed_records();
      put_multi(32'h8000_0000, 1, 0);
      put_other(32'hFFFF_FFFF, 32'd256, 2);
      flush_stream();
   endtask

   task automatic test_separator_mode();
      write_separator(1'b1);
      put_poly(32'h7FFF_FFFF, 32'd5, 2, 3, 1'b0, 0, 0);
      flush_stream();
      write_separator(1'b0);
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      put_poly(32'd40, 32'd3, 0, 3, 1'b1, 0, 0);
      flush_stream();
   endtask

   task automatic test_random_records(input int s_pct, input int r_pct);
      int start;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      start = bytes_sent;
      while (bytes_sent - start < 40 && !parse_done) begin
         put_random_record();
         flush_stream();
         if ($urandom_range(0, 5) == 0) write_separator($urandom_range(0, 1));
      end
   endtask

   task automatic test_termination();
      case ($urandom_range(0, 7))
         0: put_poly(32'd50, 32'd5, 1, 1, 1'b1, 0, 0);
         1: begin
            put_poly(32'd51, 32'd3, 1, 1, 1'b1, 0, 0);
            repeat (6) void'(stream_bytes.pop_back());
            repeat (6) void'(stream_last.pop_back());
         end
         2: begin
            put_be32(32'd52);
            put_be32(32'h8000_0010);
            put_le32(32'd5);
         end
         3: put_other(32'd53, $urandom_range(0, 1) ? 32'd257 : 32'hFFFF_FFFE, 4);
         4: begin
            put_be32(32'd54);
            put_be32(32'd16);
            put_le32(32'(srsp_pkg::TYPE_MULTIPOINT));
            for (int i = 0; i < 2; i++) put8($urandom_range(0, 255));
         end
         5: put_poly(32'd55, 32'd5, -1, 1, 1'b1, 0, 0);
         6: begin
            put_be32(32'd56);
            put_be32(32'd40);
            put_le32(32'd3);
            put_box();
            put_le32(PART_LIMIT + 1);
            put_le32(32'd2);
         end
         default: put_other(32'd57, 32'd1, 10);
      endcase
      if (stream_last.size() > 0) stream_last[stream_last.size() - 1] = 1'b1;
      flush_stream();
   endtask

   task automatic test_after_end();
      for (int i = 0; i < 8; i++) begin
         put8($urandom_range(0, 255));
         stream_last[stream_last.size() - 1] = $urandom_range(0, 1);
      end
      flush_stream();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            items_checked++;
            if (expected_items.size() == 0) begin
               $error("unexpected transfer: kind %0d status %0d", rsp_kind, rsp_status);
               failures++;
            end else begin
               srsp_pkg::item_type e;
               e = expected_items.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind: expected %0d, got %0d", e.kind, rsp_kind);
                  failures++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  failures++;
               end
               if (rsp_record_id !== e.record_id) begin
                  $error("record_id: expected %h, got %h", e.record_id, rsp_record_id);
                  failures++;
               end
               if (rsp_shape_type !== e.shape_type) begin
                  $error("shape_type: expected %0d, got %0d", e.shape_type, rsp_shape_type);
                  failures++;
               end
               if (rsp_part_index !== e.part_index) begin
                  $error("part_index: expected %0d, got %0d", e.part_index, rsp_part_index);
                  failures++;
               end
               if (rsp_part_count !== e.part_count) begin
                  $error("part_count: expected %0d, got %0d", e.part_count, rsp_part_count);
                  failures++;
               end
               if (rsp_point_count !== e.point_count) begin
                  $error("point_count: expected %0d, got %0d", e.point_count, rsp_point_count);
                  failures++;
               end
               if (rsp_x_bits !== e.x_bits) begin
                  $error("x_bits: expected %h, got %h", e.x_bits, rsp_x_bits);
                  failures++;
               end
               if (rsp_y_bits !== e.y_bits) begin
                  $error("y_bits: expected %h, got %h", e.y_bits, rsp_y_bits);
                  failures++;
               end
               if (rsp_run_end !== e.run_end) begin
                  $error("run_end: expected %0d, got %0d", e.run_end, rsp_run_end);
                  failures++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= $urandom_range(0, 99) >= recv_idle_pct;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wr_en) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("shape_record_stream_parser regression: fail");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data_byte = 8'd0;
      req_stream_end = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      pos = 0;
      file_bytes = 0;
      phase = srsp_pkg::PH_HEADER;
      shifter = 0;
      field_cnt = 0;
      rec_id = 0;
      rec_end = 0;
      cur_type = 0;
      n_parts = 0;
      n_points = 0;
      pts_done = 0;
      cursor = 0;
      x_saved = 0;
      parse_done = 1'b0;
      sep_mode = 1'b0;
      send_idle_pct = 15;
      recv_idle_pct = 76;
      hold_cycles = 0;
      failures = 0;
      bytes_sent = 0;
      items_checked = 0;
      stall_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_separator(1'b0);
      test_header();
      test_directed_records();
      test_separator_mode();
      test_backpressure();
      test_random_records(15, 76);
      test_random_records(76, 15);
      test_random_records(0, 0);
      test_termination();
      wait_drained(20);
      test_after_end();
      wait_drained(20);
      $display("Covered header, polygon, multipoint and skipped records, separator mode on and off,");
      $display("a long output stall, and %0d bytes producing %0d checked results.",
               bytes_sent, items_checked);
      if (failures == 0) begin
         $display("shape_record_stream_parser regression: pass");
      end else begin
         $display("shape_record_stream_parser regression: fail");
      end
      $finish;
   end

endmodule
